// ===== sv/sadc_pkg.sv =====
// Package for the set-associative data cache hit/miss model.
// Holds geometry defaults, command codes and configuration register indexes.
// No dependencies.
package sadc_pkg;

  localparam int unsigned DefCacheBytes = 8192;
  localparam int unsigned DefWays       = 4;
  localparam int unsigned DefLineBytes  = 32;

  localparam int unsigned SkipPeriod = 13;
  localparam int unsigned SkipW      = 4;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned PenaltyW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_STORE = 2'd1,
    CMD_SWAP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REPLACE_MODE = 2'd0,
    REG_LOAD_MISS    = 2'd1,
    REG_STORE_MISS   = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_e;

  localparam logic ACCESS_LOAD  = 1'b0;
  localparam logic ACCESS_STORE = 1'b1;

  localparam logic MODE_SHARED      = 1'b0;
  localparam logic MODE_ROUND_ROBIN = 1'b1;

endpackage

// ===== sv/set_assoc_data_cache_model.sv =====
// Set-associative data cache tag model with hit/miss penalty reporting.
// A request is taken only in idle; its set row is read into a register, the look state
// compares the tag and writes back the row on a load miss, and the registered result is
// held until out_ready_i. A swap shows a second, store result; a none command, none.
// Reset: a clearing pass writes every set row invalid, one row per cycle (NumSets
// rows, 64 by default), during which no request is taken.
module set_assoc_data_cache_model #(
  parameter int unsigned CacheBytes = sadc_pkg::DefCacheBytes,
  parameter int unsigned Ways       = sadc_pkg::DefWays,
  parameter int unsigned LineBytes  = sadc_pkg::DefLineBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sadc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sadc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [sadc_pkg::AddrW-1:0]    addr_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic                          access_kind_o,
  output logic [sadc_pkg::PenaltyW-1:0] penalty_cycles_o,
  output logic                          last_o
);
  import sadc_pkg::*;

  localparam int unsigned LineShift = $clog2(LineBytes);
  localparam int unsigned WayLog    = $clog2(Ways);
  localparam int unsigned SizeLog   = $clog2(CacheBytes);
  localparam int unsigned SetBits   =
      (SizeLog >= LineShift + WayLog) ? SizeLog - LineShift - WayLog : 0;
  localparam int unsigned NumWays   = 1 << WayLog;
  localparam int unsigned NumSets   = 1 << SetBits;
  localparam int unsigned WayW      = (WayLog > 0) ? WayLog : 1;
  localparam int unsigned SetW      = (SetBits > 0) ? SetBits : 1;
  localparam int unsigned TagW      = AddrW - LineShift - SetBits;
  localparam logic [AddrW-1:0] SetMask = AddrW'(NumSets - 1);

  typedef struct packed {
    logic [NumWays-1:0]           valid;
    logic [NumWays-1:0][TagW-1:0] tags;
    logic [WayW-1:0]              rr;
  } row_t;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_RESP  = 3'd3;

  logic [2:0] state_q, state_d;
  logic [SetW-1:0] clr_q, clr_d;

  logic replace_mode_q;
  logic [PenaltyW-1:0] load_miss_q, store_miss_q;

  logic [WayW-1:0]  shared_q, shared_d;
  logic [SkipW-1:0] skip_q, skip_d;

  logic [1:0]      cmd_q;
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;
  logic            swap_pend_q, swap_pend_d;

  logic                out_valid_q, out_valid_d;
  logic                hit_q, hit_d;
  logic                kind_q, kind_d;
  logic [PenaltyW-1:0] pen_q, pen_d;
  logic                last_q, last_d;

  row_t            mem [NumSets];
  row_t            rd_q;
  row_t            wdata;
  logic            we;
  logic [SetW-1:0] waddr;
  logic            accept;
  logic [SetW-1:0] rd_set;

  logic            lookup_hit;
  logic [WayW-1:0] victim;
  logic [WayW-1:0] victim_nxt;
  logic [WayW-1:0] shared_nxt2;
  logic [SkipW-1:0] skip_inc;
  logic            is_load;

  assign accept = in_valid_i && in_ready_o;
  assign rd_set = SetW'((addr_i >> LineShift) & SetMask);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (accept) begin
      rd_q <= mem[rd_set];
    end
  end

  always_comb begin
    lookup_hit = 1'b0;
    for (int w = 0; w < NumWays; w++) begin
      if (rd_q.valid[w] && (rd_q.tags[w] == tag_q)) begin
        lookup_hit = 1'b1;
      end
    end
  end

  assign is_load = (cmd_q == CMD_LOAD) || (cmd_q == CMD_SWAP);
  assign victim  = (replace_mode_q == MODE_ROUND_ROBIN) ? rd_q.rr : shared_q;
  assign victim_nxt = (32'(victim) + 32'd1 == NumWays) ? '0 : victim + WayW'(1);
  assign shared_nxt2 = (32'(victim_nxt) + 32'd1 == NumWays) ? '0 : victim_nxt + WayW'(1);
  assign skip_inc = skip_q + SkipW'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    shared_d    = shared_q;
    skip_d      = skip_q;
    swap_pend_d = swap_pend_q;
    out_valid_d = out_valid_q;
    hit_d       = hit_q;
    kind_d      = kind_q;
    pen_d       = pen_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = set_q;
    wdata       = rd_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + SetW'(1);
        if (clr_q == SetW'(NumSets - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cmd_q == CMD_NONE) begin
          state_d = ST_IDLE;
        end else begin
          state_d     = ST_RESP;
          out_valid_d = 1'b1;
          hit_d       = lookup_hit;
          kind_d      = is_load ? ACCESS_LOAD : ACCESS_STORE;
          pen_d       = lookup_hit ? '0 : (is_load ? load_miss_q : store_miss_q);
          last_d      = (cmd_q != CMD_SWAP);
          swap_pend_d = (cmd_q == CMD_SWAP);
          if (is_load && !lookup_hit) begin
            we                   = 1'b1;
            wdata.valid[victim]  = 1'b1;
            wdata.tags[victim]   = tag_q;
            if (replace_mode_q == MODE_ROUND_ROBIN) begin
              wdata.rr = victim_nxt;
            end else if (32'(skip_inc) >= SkipPeriod) begin
              skip_d   = '0;
              shared_d = shared_nxt2;
            end else begin
              skip_d   = skip_inc;
              shared_d = victim_nxt;
            end
          end
        end
      end
      ST_RESP: begin
        if (out_ready_i) begin
          if (swap_pend_q) begin
            // store half of a swap: the load hit or just filled the line
            swap_pend_d = 1'b0;
            hit_d       = 1'b1;
            kind_d      = ACCESS_STORE;
            pen_d       = '0;
            last_d      = 1'b1;
          end else begin
            out_valid_d = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      shared_q       <= '0;
      skip_q         <= '0;
      swap_pend_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      replace_mode_q <= MODE_SHARED;
      load_miss_q    <= '0;
      store_miss_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      shared_q    <= shared_d;
      skip_q      <= skip_d;
      swap_pend_q <= swap_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REPLACE_MODE: replace_mode_q <= cfg_data_i[0];
          REG_LOAD_MISS:    load_miss_q    <= cfg_data_i;
          REG_STORE_MISS:   store_miss_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    kind_q <= kind_d;
    pen_q  <= pen_d;
    last_q <= last_d;
    if (accept) begin
      cmd_q <= cmd_i;
      set_q <= rd_set;
      tag_q <= TagW'(addr_i >> (LineShift + SetBits));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign access_kind_o    = kind_q;
  assign penalty_cycles_o = pen_q;
  assign last_o           = last_q;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for set_assoc_data_cache_model: loads, stores and swaps
// are predicted against a local tag/victim model and every result is compared.
// Depends on sadc_pkg and the set_assoc_data_cache_model RTL.
module tb;
  import sadc_pkg::*;

  localparam int LineShift = $clog2(DefLineBytes);
  localparam int NumWays   = DefWays;
  localparam int SetBits   = $clog2(DefCacheBytes) - LineShift - $clog2(DefWays);
  localparam int NumSets   = 1 << SetBits;
  localparam int TagBits   = AddrW - LineShift - SetBits;

  typedef struct packed {
    logic                hit;
    logic                kind;
    logic [PenaltyW-1:0] penalty;
    logic                last;
  } cache_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          cmd_i;
  logic [AddrW-1:0]    addr_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                hit_o;
  logic                access_kind_o;
  logic [PenaltyW-1:0] penalty_cycles_o;
  logic                last_o;

  // predictor state
  logic [AddrW-1:0]    tag_line [NumSets][NumWays];
  bit                  line_valid [NumSets][NumWays];
  int                  rr_ptr [NumSets];
  int                  shared_ptr;
  int                  skip_cnt;
  logic                cfg_mode;
  logic [PenaltyW-1:0] load_penalty;
  logic [PenaltyW-1:0] store_penalty;

  cache_result_t       cache_results_due [$];
  int                  error_count;
  bit                  steady;
  logic [TagBits-1:0]  tag_pool [8];

  set_assoc_data_cache_model dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .addr_i           (addr_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .access_kind_o    (access_kind_o),
    .penalty_cycles_o (penalty_cycles_o),
    .last_o           (last_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

  // returns hit; a load miss fills the victim way
  function automatic bit lookup_line(logic [AddrW-1:0] addr, bit is_load);
    logic [AddrW-1:0] line;
    int               set;
    int               victim;
    line = addr >> LineShift;
    set  = int'(line & (NumSets - 1));
    for (int w = 0; w < NumWays; w++) begin
      if (line_valid[set][w] && tag_line[set][w] == line) return 1'b1;
    end
    if (!is_load) return 1'b0;
    if (cfg_mode == MODE_ROUND_ROBIN) begin
      victim = rr_ptr[set];
      rr_ptr[set] = (victim == NumWays - 1) ? 0 : victim + 1;
    end else begin
      victim = shared_ptr;
      shared_ptr = (victim == NumWays - 1) ? 0 : victim + 1;
      skip_cnt++;
      if (skip_cnt >= SkipPeriod) begin
        skip_cnt = 0;
        shared_ptr = (shared_ptr == NumWays - 1) ? 0 : shared_ptr + 1;
      end
    end
    tag_line[set][victim]   = line;
    line_valid[set][victim] = 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_access(cmd_e cmd, logic [AddrW-1:0] addr);
    bit hit;
    case (cmd)
      CMD_LOAD: begin
        hit = lookup_line(addr, 1'b1);
        cache_results_due.push_back({hit, ACCESS_LOAD, hit ? '0 : load_penalty, 1'b1});
      end
      CMD_STORE: begin
        hit = lookup_line(addr, 1'b0);
        cache_results_due.push_back({hit, ACCESS_STORE, hit ? '0 : store_penalty, 1'b1});
      end
      CMD_SWAP: begin
        hit = lookup_line(addr, 1'b1);
        cache_results_due.push_back({hit, ACCESS_LOAD, hit ? '0 : load_penalty, 1'b0});
        hit = lookup_line(addr, 1'b0);
        cache_results_due.push_back({hit, ACCESS_STORE, hit ? '0 : store_penalty, 1'b1});
      end
      default: ;
    endcase
  endfunction

  // result checker and output back-pressure
  always @(posedge clk_i) begin
    cache_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cache_results_due.size() == 0) begin
        $error("unexpected result: hit=%0d kind=%0d penalty=%0d last=%0d",
               hit_o, access_kind_o, penalty_cycles_o, last_o);
        error_count++;
      end else begin
        exp_res = cache_results_due.pop_front();
        if (hit_o !== exp_res.hit) begin
          $error("hit: expected %0d, got %0d", exp_res.hit, hit_o);
          error_count++;
        end
        if (access_kind_o !== exp_res.kind) begin
          $error("access_kind: expected %0d, got %0d", exp_res.kind, access_kind_o);
          error_count++;
        end
        if (penalty_cycles_o !== exp_res.penalty) begin
          $error("penalty_cycles: expected %0d, got %0d", exp_res.penalty, penalty_cycles_o);
          error_count++;
        end
        if (last_o !== exp_res.last) begin
          $error("last: expected %0d, got %0d", exp_res.last, last_o);
          error_count++;
        end
      end
    end
    out_ready_i <= steady || ($urandom_range(0, 99) >= 25);
  end

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_REPLACE_MODE: cfg_mode      = data[0];
      REG_LOAD_MISS:    load_penalty  = data;
      REG_STORE_MISS:   store_penalty = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic issue_request(cmd_e cmd, logic [AddrW-1:0] addr);
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    addr_i     <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    predict_access(cmd, addr);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (cache_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [AddrW-1:0] pick_addr();
    logic [SetBits-1:0] set;
    if ($urandom_range(0, 99) < 15) return $urandom();
    set = ($urandom_range(0, 3) == 0) ? SetBits'($urandom()) : SetBits'($urandom_range(0, 3));
    return {tag_pool[$urandom_range(0, 7)], set, LineShift'($urandom())};
  endfunction

  task automatic run_random(int count, int steady_from, int steady_to);
    int   r;
    cmd_e cmd;
    foreach (tag_pool[i]) tag_pool[i] = TagBits'($urandom());
    for (int n = 0; n < count; n++) begin
      steady = (n >= steady_from && n < steady_to);
      r = $urandom_range(0, 99);
      cmd = (r < 45) ? CMD_LOAD : (r < 70) ? CMD_STORE : (r < 95) ? CMD_SWAP : CMD_NONE;
      issue_request(cmd, pick_addr());
    end
    steady = 1'b0;
    wait_drain();
  endtask

  task automatic test_directed();
    write_reg(REG_UNUSED, CfgDataW'($urandom()));
    write_reg(REG_REPLACE_MODE, {15'h7FFF, MODE_SHARED});
    write_reg(REG_LOAD_MISS, 16'hFFFF);
    write_reg(REG_STORE_MISS, 16'h0000);
    issue_request(CMD_LOAD, 32'h0000_0000);
    issue_request(CMD_LOAD, 32'h0000_0000);
    issue_request(CMD_STORE, 32'h0000_001F);
    issue_request(CMD_STORE, 32'hFFFF_FFFF);
    issue_request(CMD_STORE, 32'hFFFF_FFFF);
    issue_request(CMD_LOAD, 32'hFFFF_FFFF);
    issue_request(CMD_SWAP, 32'hFFFF_FFE0);
    issue_request(CMD_SWAP, 32'h1234_5678);
    issue_request(CMD_NONE, 32'hFFFF_FFFF);
    issue_request(CMD_NONE, 32'h0000_0000);
    // five lines into one set: the fifth evicts the first
    for (int k = 1; k <= 5; k++) issue_request(CMD_LOAD, 32'(k) << (LineShift + SetBits));
    issue_request(CMD_LOAD, 32'h0000_0800);
    issue_request(CMD_STORE, 32'h0000_1000);
    issue_request(CMD_SWAP, 32'h8000_0000);
    issue_request(CMD_LOAD, 32'h7FFF_FFE0);
    wait_drain();
  endtask

  task automatic test_round_robin();
    write_reg(REG_REPLACE_MODE, {15'h0000, MODE_ROUND_ROBIN});
    write_reg(REG_LOAD_MISS, 16'h0000);
    write_reg(REG_STORE_MISS, 16'hFFFF);
    run_random(120, 0, 0);
  endtask

  task automatic test_shared_skip();
    write_reg(REG_REPLACE_MODE, {CfgDataW'($urandom()) & 16'hFFFE} | MODE_SHARED);
    write_reg(REG_LOAD_MISS, CfgDataW'($urandom()));
    write_reg(REG_STORE_MISS, CfgDataW'($urandom()));
    run_random(120, 30, 90);
  endtask

  // pointers of both kinds survive mode changes
  task automatic test_mode_switch();
    write_reg(REG_REPLACE_MODE, {15'h2AAA, MODE_ROUND_ROBIN});
    write_reg(REG_LOAD_MISS, 16'h0001);
    run_random(60, 0, 0);
    write_reg(REG_REPLACE_MODE, {15'h5555, MODE_SHARED});
    write_reg(REG_STORE_MISS, 16'h8000);
    run_random(60, 10, 40);
    write_reg(REG_REPLACE_MODE, {15'h7FFF, MODE_ROUND_ROBIN});
    write_reg(REG_LOAD_MISS, 16'hFFFF);
    run_random(40, 0, 0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    cmd_i         = '0;
    addr_i        = '0;
    out_ready_i   = 1'b0;
    steady        = 1'b0;
    error_count   = 0;
    shared_ptr    = 0;
    skip_cnt      = 0;
    cfg_mode      = MODE_SHARED;
    load_penalty  = '0;
    store_penalty = '0;
    foreach (line_valid[s, w]) begin
      line_valid[s][w] = 1'b0;
      tag_line[s][w]   = '0;
    end
    foreach (rr_ptr[s]) rr_ptr[s] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_round_robin();
    test_shared_skip();
    test_mode_switch();

    if (error_count == 0 && cache_results_due.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sadc_pkg.sv
sv/set_assoc_data_cache_model.sv
dv/tb.sv
